@@ rtl/record_stack_with_search_defines.svh @@
// assertion helpers for the checker file
`ifndef RECORD_STACK_WITH_SEARCH_DEFINES_SVH
`define RECORD_STACK_WITH_SEARCH_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet while rst_n is low
`define RSS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet while rst_n is low
`define RSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rss_pkg.sv @@
package rss_pkg;

  localparam int NAME_BYTES = 20;
  localparam int DEPTH      = 16;
  localparam int NAME_W     = 160;
  localparam int VAL_W      = 16;
  localparam int CAP_W      = 5;
  localparam int CNT_W      = 5;
  localparam int SIZE_W     = 5;
  localparam int STATUS_W   = 2;
  localparam int OP_W       = 3;
  localparam int IN_DATA_W  = 192;
  localparam int OUT_DATA_W = 208;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;
  // register index bit of the config address (byte address / 4)
  localparam logic REG_IDX_CAPACITY = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_NOMATCH = 2'd3
  } status_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_SEARCH = 3'd3,
    OP_DUMP   = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_CMP,
    S_FINISH
  } state_t;

  // source of the fields loaded into the output register
  typedef enum logic [1:0] {
    SRC_IN,
    SRC_RD,
    SRC_PEND,
    SRC_ERR
  } src_t;

  typedef struct packed {
    logic    load;
    logic    push_wr;
    logic    pop;
    logic    idx_top;
    logic    idx_zero;
    logic    idx_inc;
    logic    rd_en;
    logic    pend_load;
    logic    emit;
    src_t    src;
    status_t code;
    logic    last;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    full;
    logic    empty;
    logic    match;
    logic    at_end;
    logic    pend_valid;
    logic    out_free;
  } dp_stat_t;

  // c-string cleanup: every byte from the first zero byte on is cleared
  function automatic logic [NAME_W-1:0] clean_name(input logic [NAME_W-1:0] w);
    logic              alive;
    logic [NAME_W-1:0] r;
    alive = 1'b1;
    r     = '0;
    for (int k = 0; k < NAME_W / 8; k++) begin
      alive = alive && (k < NAME_BYTES) && (w[8*k +: 8] != 8'h00);
      if (alive) begin
        r[8*k +: 8] = w[8*k +: 8];
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/rss_ctrl.sv @@
module rss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rss_pkg::dp_stat_t stat,
  output rss_pkg::dp_cmd_t  cmd
);

  rss_pkg::state_t state_r;
  rss_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rss_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.src   = rss_pkg::SRC_ERR;
    cmd.code  = rss_pkg::ST_OK;
    unique case (state_r)
      rss_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = rss_pkg::S_DECODE;
        end
      end
      rss_pkg::S_DECODE: begin
        unique case (stat.op) inside
          rss_pkg::OP_PUSH: begin
            if (stat.out_free) begin
              cmd.emit = 1'b1;
              cmd.last = 1'b1;
              if (stat.full) begin
                cmd.code = rss_pkg::ST_FULL;
              end else begin
                cmd.src     = rss_pkg::SRC_IN;
                cmd.push_wr = 1'b1;
              end
              state_nxt = rss_pkg::S_IDLE;
            end
          end
          rss_pkg::OP_POP, rss_pkg::OP_PEEK, rss_pkg::OP_DUMP: begin
            if (stat.empty) begin
              if (stat.out_free) begin
                cmd.emit  = 1'b1;
                cmd.last  = 1'b1;
                cmd.code  = rss_pkg::ST_EMPTY;
                state_nxt = rss_pkg::S_IDLE;
              end
            end else begin
              cmd.idx_top  = (stat.op != rss_pkg::OP_DUMP);
              cmd.idx_zero = (stat.op == rss_pkg::OP_DUMP);
              state_nxt    = rss_pkg::S_READ;
            end
          end
          rss_pkg::OP_SEARCH: begin
            cmd.idx_zero = 1'b1;
            state_nxt    = stat.empty ? rss_pkg::S_FINISH : rss_pkg::S_READ;
          end
          default: begin
            state_nxt = rss_pkg::S_IDLE;
          end
        endcase
      end
      rss_pkg::S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = rss_pkg::S_CMP;
      end
      rss_pkg::S_CMP: begin
        unique case (stat.op) inside
          rss_pkg::OP_POP, rss_pkg::OP_PEEK: begin
            if (stat.out_free) begin
              cmd.emit  = 1'b1;
              cmd.src   = rss_pkg::SRC_RD;
              cmd.last  = 1'b1;
              cmd.pop   = (stat.op == rss_pkg::OP_POP);
              state_nxt = rss_pkg::S_IDLE;
            end
          end
          rss_pkg::OP_DUMP: begin
            if (stat.out_free) begin
              cmd.emit = 1'b1;
              cmd.src  = rss_pkg::SRC_RD;
              cmd.last = stat.at_end;
              if (stat.at_end) begin
                state_nxt = rss_pkg::S_IDLE;
              end else begin
                cmd.idx_inc = 1'b1;
                state_nxt   = rss_pkg::S_READ;
              end
            end
          end
          rss_pkg::OP_SEARCH: begin
            // a match is held back one step so the final one can carry last
            if (!(stat.match && stat.pend_valid && !stat.out_free)) begin
              if (stat.match) begin
                cmd.pend_load = 1'b1;
                if (stat.pend_valid) begin
                  cmd.emit = 1'b1;
                  cmd.src  = rss_pkg::SRC_PEND;
                end
              end
              if (stat.at_end) begin
                state_nxt = rss_pkg::S_FINISH;
              end else begin
                cmd.idx_inc = 1'b1;
                state_nxt   = rss_pkg::S_READ;
              end
            end
          end
          default: begin
            state_nxt = rss_pkg::S_IDLE;
          end
        endcase
      end
      rss_pkg::S_FINISH: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.last  = 1'b1;
          cmd.src   = stat.pend_valid ? rss_pkg::SRC_PEND : rss_pkg::SRC_ERR;
          cmd.code  = rss_pkg::ST_NOMATCH;
          state_nxt = rss_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rss_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/rss_datapath.sv @@
module rss_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [rss_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [rss_pkg::OP_W-1:0]         in_tuser,
  input  logic [rss_pkg::CAP_W-1:0]        capacity,
  input  rss_pkg::dp_cmd_t                 cmd,
  output rss_pkg::dp_stat_t                stat,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rss_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [rss_pkg::STATUS_W-1:0]     out_tuser,
  output logic                             out_tlast
);

  localparam int DEPTH = rss_pkg::DEPTH;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = $clog2(DEPTH + 1);
  localparam int LW = (PW > rss_pkg::CAP_W) ? PW : rss_pkg::CAP_W;
  localparam int NW = rss_pkg::NAME_W;
  localparam int VW = rss_pkg::VAL_W;

  // record storage
  logic [NW-1:0] name_mem_r   [DEPTH];
  logic [VW-1:0] height_mem_r [DEPTH];
  logic [VW-1:0] vision_mem_r [DEPTH];

  rss_pkg::opcode_t op_r;
  logic [NW-1:0]    key_r;
  logic [VW-1:0]    height_r;
  logic [VW-1:0]    vision_r;

  logic [PW-1:0]    top_r;
  logic [PW-1:0]    top_nxt;
  logic [AW-1:0]    idx_r;
  logic [PW-1:0]    count_r;

  logic [NW-1:0]    rd_name_r;
  logic [VW-1:0]    rd_height_r;
  logic [VW-1:0]    rd_vision_r;

  logic             pend_valid_r;
  logic [NW-1:0]    pend_name_r;
  logic [VW-1:0]    pend_height_r;
  logic [VW-1:0]    pend_vision_r;
  logic [PW-1:0]    pend_count_r;

  logic                          out_valid_r;
  logic [NW-1:0]                 out_name_r;
  logic [VW-1:0]                 out_height_r;
  logic [VW-1:0]                 out_vision_r;
  logic [rss_pkg::CNT_W-1:0]     out_count_r;
  logic [rss_pkg::SIZE_W-1:0]    out_size_r;
  rss_pkg::status_t              out_status_r;
  logic                          out_last_r;

  logic [NW-1:0]                 out_name_nxt;
  logic [VW-1:0]                 out_height_nxt;
  logic [VW-1:0]                 out_vision_nxt;
  logic [rss_pkg::CNT_W-1:0]     out_count_nxt;
  rss_pkg::status_t              out_status_nxt;

  assign top_nxt = top_r + PW'(cmd.push_wr) - PW'(cmd.pop);

  assign stat.op         = op_r;
  assign stat.full       = (top_r >= PW'(DEPTH)) || (LW'(top_r) >= LW'(capacity));
  assign stat.empty      = (top_r == '0);
  assign stat.match      = (rd_name_r == key_r);
  assign stat.at_end     = ((PW'(idx_r) + PW'(1)) == top_r);
  assign stat.pend_valid = pend_valid_r;
  assign stat.out_free   = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      top_r <= top_nxt;
      if (cmd.idx_zero) begin
        pend_valid_r <= 1'b0;
      end else if (cmd.pend_load) begin
        pend_valid_r <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // memory write at the top, registered read at the walk index
  always_ff @(posedge clk) begin
    if (cmd.push_wr) begin
      name_mem_r[top_r[AW-1:0]]   <= key_r;
      height_mem_r[top_r[AW-1:0]] <= height_r;
      vision_mem_r[top_r[AW-1:0]] <= vision_r;
    end
    if (cmd.rd_en) begin
      rd_name_r   <= name_mem_r[idx_r];
      rd_height_r <= height_mem_r[idx_r];
      rd_vision_r <= vision_mem_r[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= rss_pkg::opcode_t'(in_tuser);
      key_r    <= rss_pkg::clean_name(in_tdata[NW-1:0]);
      height_r <= in_tdata[NW +: VW];
      vision_r <= in_tdata[NW+VW +: VW];
    end
    if (cmd.idx_top) begin
      idx_r <= AW'(top_r - PW'(1));
    end else if (cmd.idx_zero) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + AW'(1);
    end
    if (cmd.idx_zero) begin
      count_r <= '0;
    end else if (cmd.pend_load) begin
      count_r <= count_r + PW'(1);
    end
    if (cmd.pend_load) begin
      pend_name_r   <= rd_name_r;
      pend_height_r <= rd_height_r;
      pend_vision_r <= rd_vision_r;
      pend_count_r  <= count_r + PW'(1);
    end
    if (cmd.emit) begin
      out_name_r   <= out_name_nxt;
      out_height_r <= out_height_nxt;
      out_vision_r <= out_vision_nxt;
      out_count_r  <= out_count_nxt;
      out_size_r   <= rss_pkg::SIZE_W'(top_nxt);
      out_status_r <= out_status_nxt;
      out_last_r   <= cmd.last;
    end
  end

  always_comb begin
    out_name_nxt   = '0;
    out_height_nxt = '0;
    out_vision_nxt = '0;
    out_count_nxt  = '0;
    out_status_nxt = rss_pkg::ST_OK;
    case (cmd.src)
      rss_pkg::SRC_IN: begin
        out_name_nxt   = key_r;
        out_height_nxt = height_r;
        out_vision_nxt = vision_r;
      end
      rss_pkg::SRC_RD: begin
        out_name_nxt   = rd_name_r;
        out_height_nxt = rd_height_r;
        out_vision_nxt = rd_vision_r;
      end
      rss_pkg::SRC_PEND: begin
        out_name_nxt   = pend_name_r;
        out_height_nxt = pend_height_r;
        out_vision_nxt = pend_vision_r;
        out_count_nxt  = rss_pkg::CNT_W'(pend_count_r);
      end
      default: begin
        out_status_nxt = cmd.code;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {6'b0, out_size_r, out_count_r, out_vision_r, out_height_r, out_name_r};

endmodule

@@ rtl/record_stack_with_search.sv @@
// Bounded LIFO stack of named records with search by name.
// Input channel (in_*): one operation per transfer, opcode in in_tuser.
// Result channel (out_*): one or more transfers per operation, out_tlast
// marks the final result, out_tuser carries the status code.
// Config port (cfg_*): capacity at byte address 0, written and read back.
// Each operation is decoded first; a push, or a full or empty result, is
// emitted from the decode state. Pop, peek, dump and search read the
// record memory one entry per step of a read state and a compare state;
// dump and search walk every stored record from the bottom of the stack.
// A search holds each match back one step so the final one can carry last.
// Operations are handled one at a time; in_tready is high only while the
// controller is idle, so a new operation is taken only once the final
// result of the last one has been loaded into the output register.
// Reset empties the stack and sets capacity to 10; record memory is not
// cleared, only entries below the stack size are ever read.
// A result waits in the output register while out_tready is low, and the
// controller stalls until it has been taken.
module record_stack_with_search (
  input  logic                               clk,
  input  logic                               rst_n,
  // name_a[63:0], name_b[127:64], name_c[159:128], height[175:160],
  // vision[191:176]
  input  logic [rss_pkg::IN_DATA_W-1:0]      in_tdata,
  // opcode[2:0]
  input  logic [rss_pkg::OP_W-1:0]           in_tuser,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // out_name_a[63:0], out_name_b[127:64], out_name_c[159:128],
  // out_height[175:160], out_vision[191:176], match_count[196:192],
  // stack_size[201:197], zero fill[207:202]
  output logic [rss_pkg::OUT_DATA_W-1:0]     out_tdata,
  // status[1:0]
  output logic [rss_pkg::STATUS_W-1:0]       out_tuser,
  output logic                               out_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [rss_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [rss_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [rss_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);

  logic [rss_pkg::CAP_W-1:0] capacity_r;
  logic                      cfg_wr;
  rss_pkg::dp_cmd_t          cmd;
  rss_pkg::dp_stat_t         stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == rss_pkg::REG_IDX_CAPACITY);
  assign cfg_prdata = (cfg_paddr[2] == rss_pkg::REG_IDX_CAPACITY) ?
                      rss_pkg::CFG_DATA_W'(capacity_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= rss_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      capacity_r <= cfg_pwdata[rss_pkg::CAP_W-1:0];
    end
  end

  rss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rss_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .capacity   (capacity_r),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ rtl/record_stack_with_search_checker.sv @@
`include "record_stack_with_search_defines.svh"

module record_stack_with_search_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [rss_pkg::OUT_DATA_W-1:0]     out_tdata,
  input logic [rss_pkg::STATUS_W-1:0]       out_tuser,
  input logic                               out_tlast,
  input logic                               out_tvalid,
  input logic                               out_tready
);

  // a stalled result holds
  `RSS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast),
    "result changed while stalled")

  // error results are single and carry no record
  `RSS_ASSERT_SAME(a_err_single, out_tvalid && (out_tuser != rss_pkg::ST_OK),
    out_tlast && (out_tdata[191:0] == '0),
    "error result not last or record not zero")

  `RSS_ASSERT_SAME(a_nomatch_count, out_tvalid && (out_tuser == rss_pkg::ST_NOMATCH),
    out_tdata[196:192] == '0,
    "no-match result with nonzero match count")

  // one operation at a time
  `RSS_ASSERT_NEXT(a_one_op, in_tvalid && in_tready, !in_tready,
    "input taken while an operation is in progress")

endmodule

bind record_stack_with_search record_stack_with_search_checker u_checker (.*);

@@ bench/tb_record_stack_with_search.sv @@
module tb_record_stack_with_search;

  localparam int STACK_DEPTH   = rss_pkg::DEPTH;
  localparam int SETTLE_CYCLES = 2 * STACK_DEPTH + 8;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int POOL_SIZE     = 6;
  localparam int SIDE_TX       = 0;
  localparam int SIDE_RX       = 1;
  localparam int PRINT_LIMIT   = 40;

  localparam logic [rss_pkg::CFG_ADDR_W-1:0] CAPACITY_ADDR =
    {rss_pkg::REG_IDX_CAPACITY, 2'b00};
  // codes outside the operation set, the block must swallow them silently
  localparam logic [rss_pkg::OP_W-1:0] OP_BAD_FIRST = 3'd5;
  localparam logic [rss_pkg::OP_W-1:0] OP_BAD_LAST  = 3'd7;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  // name_a[63:0], name_b[127:64], name_c[159:128], height[175:160],
  // vision[191:176]
  logic [rss_pkg::IN_DATA_W-1:0]    in_tdata = '0;
  // opcode[2:0]
  logic [rss_pkg::OP_W-1:0]         in_tuser = '0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  // out_name_a[63:0], out_name_b[127:64], out_name_c[159:128],
  // out_height[175:160], out_vision[191:176], match_count[196:192],
  // stack_size[201:197], zero fill[207:202]
  logic [rss_pkg::OUT_DATA_W-1:0]   out_tdata;
  // status[1:0]
  logic [rss_pkg::STATUS_W-1:0]     out_tuser;
  logic                             out_tlast;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic                             cfg_psel = 1'b0;
  logic                             cfg_penable = 1'b0;
  logic                             cfg_pwrite = 1'b0;
  logic [rss_pkg::CFG_ADDR_W-1:0]   cfg_paddr = '0;
  logic [rss_pkg::CFG_DATA_W-1:0]   cfg_pwdata = '0;
  logic [rss_pkg::CFG_DATA_W-1:0]   cfg_prdata;
  logic                             cfg_pready;

  record_stack_with_search uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  typedef struct {
    rss_pkg::status_t            st;
    logic [rss_pkg::NAME_W-1:0]  name;
    logic [rss_pkg::VAL_W-1:0]   height;
    logic [rss_pkg::VAL_W-1:0]   vision;
    logic [rss_pkg::CNT_W-1:0]   hits;
    logic [rss_pkg::SIZE_W-1:0]  size;
    logic                        last;
  } stack_answer_t;

  // shadow copy of the stack and its capacity register
  logic [rss_pkg::NAME_W-1:0] name_mem [STACK_DEPTH];
  logic [rss_pkg::VAL_W-1:0]  height_mem [STACK_DEPTH];
  logic [rss_pkg::VAL_W-1:0]  vision_mem [STACK_DEPTH];
  int                         depth_now = 0;
  int                         cap_reg = int'(rss_pkg::CAP_RESET);
  stack_answer_t              due_answers [$];

  logic [rss_pkg::NAME_W-1:0] name_pool [POOL_SIZE];
  bit                         filling = 1'b1;

  int  run_left [2] = '{0, 0};
  bit  busy_mode [2] = '{0, 0};
  int  hold_request = 0;
  int  rx_hold = 0;
  int  rx_wait = 0;

  int  cycle_count = 0;
  int  fail_count = 0;
  int  results_seen = 0;
  int  op_count [5] = '{0, 0, 0, 0, 0};
  int  ignored_count = 0;
  int  full_count = 0;
  int  empty_count = 0;
  int  nomatch_count = 0;
  int  max_depth = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timed out at cycle %0d with %0d results outstanding", cycle_count,
               due_answers.size());
      $display("FAIL record_stack_with_search");
      $finish;
    end
  end

  // names follow c-string rules: everything from the first zero byte is dropped
  function automatic logic [rss_pkg::NAME_W-1:0] strip_name(
      input logic [rss_pkg::NAME_W-1:0] raw);
    logic [rss_pkg::NAME_W-1:0] res;
    logic                       ended;
    res   = '0;
    ended = 1'b0;
    for (int k = 0; k < rss_pkg::NAME_W / 8; k++) begin
      if (k >= rss_pkg::NAME_BYTES || raw[8*k +: 8] == 8'h00) ended = 1'b1;
      if (!ended) res[8*k +: 8] = raw[8*k +: 8];
    end
    return res;
  endfunction

  function automatic logic [rss_pkg::NAME_W-1:0] random_bits();
    logic [rss_pkg::NAME_W-1:0] w;
    for (int k = 0; k < rss_pkg::NAME_W / 32; k++) w[32*k +: 32] = $urandom;
    return w;
  endfunction

  // fresh junk behind the terminator, same visible name
  function automatic logic [rss_pkg::NAME_W-1:0] smear_tail(
      input logic [rss_pkg::NAME_W-1:0] n);
    logic [rss_pkg::NAME_W-1:0] r;
    logic                       ended;
    r     = n;
    ended = 1'b0;
    for (int k = 0; k < rss_pkg::NAME_BYTES; k++) begin
      if (ended) r[8*k +: 8] = ($urandom_range(0, 1) != 0) ? 8'($urandom) : 8'h00;
      if (r[8*k +: 8] == 8'h00) ended = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [rss_pkg::NAME_W-1:0] make_name();
    logic [rss_pkg::NAME_W-1:0] n;
    int                         len;
    n   = '0;
    len = ($urandom_range(0, 3) == 0) ? rss_pkg::NAME_BYTES :
          $urandom_range(0, rss_pkg::NAME_BYTES);
    for (int k = 0; k < len; k++) n[8*k +: 8] = 8'($urandom_range(1, 255));
    return smear_tail(n);
  endfunction

  function automatic int draw_gap(input int side);
    if (run_left[side] == 0) begin
      run_left[side]  = $urandom_range(8, 40);
      busy_mode[side] = ($urandom_range(0, 2) != 0);
    end
    run_left[side]--;
    return busy_mode[side] ? $urandom_range(0, 12) : 0;
  endfunction

  function automatic void add_answer(input rss_pkg::status_t st, input int idx,
                                     input int hits, input logic last);
    stack_answer_t a;
    a.st   = st;
    a.hits = rss_pkg::CNT_W'(hits);
    a.size = rss_pkg::SIZE_W'(depth_now);
    a.last = last;
    if (idx >= 0) begin
      a.name   = name_mem[idx];
      a.height = height_mem[idx];
      a.vision = vision_mem[idx];
    end else begin
      a.name   = '0;
      a.height = '0;
      a.vision = '0;
    end
    due_answers.push_back(a);
    case (st)
      rss_pkg::ST_FULL:    full_count++;
      rss_pkg::ST_EMPTY:   empty_count++;
      rss_pkg::ST_NOMATCH: nomatch_count++;
      default: ;
    endcase
  endfunction

  function automatic void run_stack_op(input logic [rss_pkg::OP_W-1:0] op,
                                       input logic [rss_pkg::NAME_W-1:0] raw,
                                       input logic [rss_pkg::VAL_W-1:0] h,
                                       input logic [rss_pkg::VAL_W-1:0] v);
    logic [rss_pkg::NAME_W-1:0] key;
    int                         lim;
    int                         hits;
    key  = strip_name(raw);
    lim  = (cap_reg < STACK_DEPTH) ? cap_reg : STACK_DEPTH;
    hits = 0;
    if (op <= rss_pkg::OP_DUMP) op_count[op]++;
    else ignored_count++;
    case (op) inside
      rss_pkg::OP_PUSH: begin
        if (depth_now >= lim) begin
          add_answer(rss_pkg::ST_FULL, -1, 0, 1'b1);
        end else begin
          name_mem[depth_now]   = key;
          height_mem[depth_now] = h;
          vision_mem[depth_now] = v;
          depth_now++;
          if (depth_now > max_depth) max_depth = depth_now;
          add_answer(rss_pkg::ST_OK, depth_now - 1, 0, 1'b1);
        end
      end
      rss_pkg::OP_POP, rss_pkg::OP_PEEK: begin
        if (depth_now == 0) begin
          add_answer(rss_pkg::ST_EMPTY, -1, 0, 1'b1);
        end else if (op == rss_pkg::OP_POP) begin
          depth_now--;
          add_answer(rss_pkg::ST_OK, depth_now, 0, 1'b1);
        end else begin
          add_answer(rss_pkg::ST_OK, depth_now - 1, 0, 1'b1);
        end
      end
      rss_pkg::OP_SEARCH: begin
        for (int i = 0; i < depth_now; i++) begin
          if (name_mem[i] == key) begin
            hits++;
            add_answer(rss_pkg::ST_OK, i, hits, 1'b0);
          end
        end
        if (hits == 0) add_answer(rss_pkg::ST_NOMATCH, -1, 0, 1'b1);
        else due_answers[due_answers.size() - 1].last = 1'b1;
      end
      rss_pkg::OP_DUMP: begin
        if (depth_now == 0) begin
          add_answer(rss_pkg::ST_EMPTY, -1, 0, 1'b1);
        end else begin
          for (int i = 0; i < depth_now; i++)
            add_answer(rss_pkg::ST_OK, i, 0, i == depth_now - 1);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string label, input logic [63:0] got,
                                 input logic [63:0] want);
    if (fail_count < PRINT_LIMIT)
      $display("mismatch at cycle %0d, %s: got %0h, expected %0h", cycle_count, label,
               got, want);
    fail_count++;
  endtask

  task automatic check_field(input string label, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(label, got, want);
  endtask

  always @(posedge clk) begin : answer_check
    stack_answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (due_answers.size() == 0) begin
        report_mismatch("result with nothing expected", out_tdata[63:0], '0);
      end else begin
        want = due_answers.pop_front();
        check_field("status", out_tuser, want.st);
        check_field("name_a", out_tdata[63:0], want.name[63:0]);
        check_field("name_b", out_tdata[127:64], want.name[127:64]);
        check_field("name_c", out_tdata[159:128], want.name[159:128]);
        check_field("height", out_tdata[175:160], want.height);
        check_field("vision", out_tdata[191:176], want.vision);
        check_field("match_count", out_tdata[196:192], want.hits);
        check_field("stack_size", out_tdata[201:197], want.size);
        check_field("zero fill", out_tdata[207:202], '0);
        check_field("last", out_tlast, want.last);
      end
    end
  end

  // result side: random stalls after each transfer, plus an occasional long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_request > 0) begin
        rx_hold      = hold_request;
        hold_request = 0;
      end
      if (out_tvalid && out_tready) rx_wait = draw_gap(SIDE_RX);
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // valid stays up after a transfer when the next item follows with no gap
  task automatic send_op(input logic [rss_pkg::OP_W-1:0] op,
                         input logic [rss_pkg::NAME_W-1:0] name,
                         input logic [rss_pkg::VAL_W-1:0] h,
                         input logic [rss_pkg::VAL_W-1:0] v);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {v, h, name};
    do @(posedge clk); while (!in_tready);
    run_stack_op(op, name, h, v);
    gap = draw_gap(SIDE_TX);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (due_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input int value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CAPACITY_ADDR;
    cfg_pwdata  <= rss_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cap_reg = value;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic cfg_read_check();
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= CAPACITY_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    check_field("capacity readback", cfg_prdata, rss_pkg::CFG_DATA_W'(cap_reg));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic send_random_op();
    int                         lim;
    int                         roll;
    logic [rss_pkg::OP_W-1:0]   op;
    logic [rss_pkg::NAME_W-1:0] name;
    logic [rss_pkg::VAL_W-1:0]  h;
    logic [rss_pkg::VAL_W-1:0]  v;
    lim = (cap_reg < STACK_DEPTH) ? cap_reg : STACK_DEPTH;
    // swing the stack between empty and full
    if (depth_now == 0) filling = 1'b1;
    else if (depth_now >= lim) filling = 1'b0;
    roll = $urandom_range(0, 99);
    if (roll >= 97) op = rss_pkg::OP_W'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
    else if (roll >= 90) op = rss_pkg::OP_DUMP;
    else if (roll >= 73) op = rss_pkg::OP_SEARCH;
    else if (roll >= 65) op = rss_pkg::OP_PEEK;
    else if (filling ? roll >= 55 : roll >= 15) op = rss_pkg::OP_POP;
    else op = rss_pkg::OP_PUSH;
    name = random_bits();
    if (op == rss_pkg::OP_PUSH || op == rss_pkg::OP_SEARCH) begin
      if ($urandom_range(0, 4) == 0) name = make_name();
      else name = smear_tail(name_pool[$urandom_range(0, POOL_SIZE - 1)]);
    end
    h = rss_pkg::VAL_W'($urandom);
    v = rss_pkg::VAL_W'($urandom);
    case ($urandom_range(0, 9))
      0: h = '0;
      1: h = '1;
      2: v = '0;
      3: v = '1;
      default: ;
    endcase
    send_op(op, name, h, v);
  endtask

  task automatic test_empty_stack();
    cfg_read_check();
    send_op(rss_pkg::OP_POP, random_bits(), '1, '1);
    send_op(rss_pkg::OP_PEEK, random_bits(), '0, '0);
    send_op(rss_pkg::OP_DUMP, random_bits(), '1, '0);
    send_op(rss_pkg::OP_SEARCH, make_name(), '0, '1);
  endtask

  task automatic test_record_extremes();
    logic [rss_pkg::NAME_W-1:0] short_name;
    logic [rss_pkg::NAME_W-1:0] blank_key;
    short_name = random_bits();
    short_name[23:0] = {8'h00, 8'h42, 8'h41};
    blank_key = random_bits();
    blank_key[7:0] = 8'h00;
    send_op(rss_pkg::OP_PUSH, '1, '1, '1);
    send_op(rss_pkg::OP_PUSH, '0, '0, '0);
    send_op(rss_pkg::OP_PUSH, short_name, 16'h1234, 16'h8000);
    send_op(rss_pkg::OP_PEEK, random_bits(), '0, '0);
    send_op(rss_pkg::OP_SEARCH, smear_tail(short_name), '0, '0);
    send_op(rss_pkg::OP_SEARCH, blank_key, '0, '0);
    send_op(rss_pkg::OP_SEARCH, '1, '0, '0);
    send_op(rss_pkg::OP_DUMP, random_bits(), '0, '0);
    send_op(rss_pkg::OP_POP, random_bits(), '0, '0);
  endtask

  task automatic test_capacity_edges();
    wait_idle();
    // limit below the current size: pushes refused, pops still served
    cfg_write(1);
    cfg_read_check();
    send_op(rss_pkg::OP_PUSH, make_name(), '1, '0);
    send_op(rss_pkg::OP_POP, random_bits(), '0, '0);
    send_op(rss_pkg::OP_POP, random_bits(), '0, '0);
    send_op(rss_pkg::OP_PUSH, make_name(), 16'h00ff, 16'hff00);
    send_op(rss_pkg::OP_PUSH, make_name(), '0, '1);
    wait_idle();
    cfg_write(0);
    cfg_read_check();
    send_op(rss_pkg::OP_PUSH, make_name(), '1, '1);
    send_op(rss_pkg::OP_POP, random_bits(), '0, '0);
    send_op(rss_pkg::OP_PEEK, random_bits(), '0, '0);
  endtask

  task automatic test_unknown_opcodes();
    wait_idle();
    cfg_write(5);
    send_op(rss_pkg::OP_PUSH, make_name(), 16'hbeef, 16'h1000);
    for (int c = OP_BAD_FIRST; c <= OP_BAD_LAST; c++)
      send_op(rss_pkg::OP_W'(c), random_bits(), rss_pkg::VAL_W'($urandom),
              rss_pkg::VAL_W'($urandom));
    send_op(rss_pkg::OP_PEEK, random_bits(), '0, '0);
  endtask

  task automatic test_deep_stack();
    logic [rss_pkg::NAME_W-1:0] shared_name;
    wait_idle();
    cfg_write(STACK_DEPTH);
    cfg_read_check();
    shared_name = make_name();
    while (depth_now > 0) send_op(rss_pkg::OP_POP, random_bits(), '0, '0);
    while (depth_now < STACK_DEPTH)
      send_op(rss_pkg::OP_PUSH, smear_tail(shared_name), rss_pkg::VAL_W'($urandom),
              rss_pkg::VAL_W'($urandom));
    send_op(rss_pkg::OP_PUSH, make_name(), '1, '1);
    send_op(rss_pkg::OP_SEARCH, smear_tail(shared_name), '0, '0);
    send_op(rss_pkg::OP_DUMP, random_bits(), '0, '0);
    repeat (STACK_DEPTH / 2) send_op(rss_pkg::OP_POP, random_bits(), '0, '0);
  endtask

  task automatic test_random_traffic(input int cap, input int items);
    wait_idle();
    cfg_write(cap);
    cfg_read_check();
    foreach (name_pool[i]) name_pool[i] = make_name();
    repeat (items) send_random_op();
  endtask

  task automatic test_backpressure();
    wait_idle();
    cfg_write(12);
    foreach (name_pool[i]) name_pool[i] = make_name();
    hold_request = 250;
    repeat (40) send_random_op();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_stack();
    test_record_extremes();
    test_capacity_edges();
    test_unknown_opcodes();
    test_deep_stack();
    test_random_traffic(STACK_DEPTH, 150);
    test_random_traffic(int'(rss_pkg::CAP_RESET), 100);
    test_random_traffic(15, 100);
    test_backpressure();
    test_random_traffic($urandom_range(2, 9), 100);
    wait_idle();
    $display("ran %0d push, %0d pop, %0d peek, %0d search, %0d dump and %0d undefined ops",
             op_count[rss_pkg::OP_PUSH], op_count[rss_pkg::OP_POP],
             op_count[rss_pkg::OP_PEEK], op_count[rss_pkg::OP_SEARCH],
             op_count[rss_pkg::OP_DUMP], ignored_count);
    $display("%0d results checked, deepest stack %0d, %0d full, %0d empty, %0d no-match",
             results_seen, max_depth, full_count, empty_count, nomatch_count);
    if (fail_count == 0) begin
      $display("PASS record_stack_with_search");
    end else begin
      $display("FAIL record_stack_with_search");
    end
    $finish;
  end

endmodule
